FILE: design/epenc_pkg.sv
`timescale 1ns / 1ps

package epenc_pkg;

  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [15:0] NARROW_MAX = 16'h007F;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_NARROW,
    KIND_WIDE
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic [15:0] unit;
  } item_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'h0, nib};
    end else begin
      d = 8'h41 + {4'h0, nib} - 8'd10;
    end
    return d;
  endfunction

  function automatic logic passes_through(input logic [15:0] c);
    logic ok;
    ok = 1'b0;
    if (c >= 16'h0041 && c <= 16'h005A) ok = 1'b1;
    if (c >= 16'h0061 && c <= 16'h007A) ok = 1'b1;
    if (c >= 16'h0030 && c <= 16'h0039) ok = 1'b1;
    if (c == 16'h002D || c == 16'h005F || c == 16'h002E || c == 16'h0021 ||
        c == 16'h007E || c == 16'h002A || c == 16'h0027 || c == 16'h0028 ||
        c == 16'h0029) ok = 1'b1;
    return ok;
  endfunction

  // index of the final byte of a run
  function automatic logic [2:0] last_idx(input kind_e k);
    logic [2:0] r;
    unique case (k)
      KIND_PASS:   r = 3'd0;
      KIND_NARROW: r = 3'd2;
      KIND_WIDE:   r = 3'd5;
      default:     r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/epenc_front.sv
`timescale 1ns / 1ps

module epenc_front
  import epenc_pkg::*;
(
  input  logic        push_i,
  input  logic [15:0] code_unit_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output item_t       q_item_o
);

  always_comb begin
    q_item_o.unit = code_unit_i;
    priority if (passes_through(code_unit_i)) begin
      q_item_o.kind = KIND_PASS;
    end else if (code_unit_i <= NARROW_MAX) begin
      q_item_o.kind = KIND_NARROW;
    end else begin
      q_item_o.kind = KIND_WIDE;
    end
  end

  assign q_push_o = push_i & ~q_full_i;

endmodule

FILE: design/epenc_queue.sv
`timescale 1ns / 1ps

module epenc_queue
  import epenc_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o,
  output logic  full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign empty_o = (cnt_q == '0);
  assign full_o = (cnt_q == CntW'(Depth));
  assign item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i) rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

FILE: design/epenc_back.sv
`timescale 1ns / 1ps

module epenc_back
  import epenc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  item_t      q_item_i,
  input  logic       q_empty_i,
  output logic       q_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);

  item_t cur_q;
  logic cur_valid_q, cur_valid_d;
  logic [2:0] idx_q, idx_d;
  logic [7:0] byte_q;
  logic last_q;
  logic out_valid_q;

  logic advance, is_last, take;
  logic [7:0] byte_sel;

  assign advance = cur_valid_q & (~out_valid_q | pop_i);
  assign is_last = (idx_q == last_idx(cur_q.kind));
  assign take = ~cur_valid_q | (advance & is_last);
  assign q_pop_o = take & ~q_empty_i;

  always_comb begin
    byte_sel = CH_PCT;
    unique case (cur_q.kind)
      KIND_PASS: byte_sel = cur_q.unit[7:0];
      KIND_NARROW: begin
        unique case (idx_q)
          3'd1:    byte_sel = hex_digit(cur_q.unit[7:4]);
          3'd2:    byte_sel = hex_digit(cur_q.unit[3:0]);
          default: byte_sel = CH_PCT;
        endcase
      end
      KIND_WIDE: begin
        unique case (idx_q)
          3'd1:    byte_sel = CH_U;
          3'd2:    byte_sel = hex_digit(cur_q.unit[15:12]);
          3'd3:    byte_sel = hex_digit(cur_q.unit[11:8]);
          3'd4:    byte_sel = hex_digit(cur_q.unit[7:4]);
          3'd5:    byte_sel = hex_digit(cur_q.unit[3:0]);
          default: byte_sel = CH_PCT;
        endcase
      end
      default: byte_sel = CH_PCT;
    endcase
  end

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d = idx_q;
    if (advance) idx_d = idx_q + 3'd1;
    if (take) begin
      cur_valid_d = ~q_empty_i;
      idx_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_item_i;
    if (advance) begin
      byte_q <= byte_sel;
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q <= idx_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o = ~out_valid_q;
  assign out_byte_o = byte_q;
  assign run_last_o = last_q;

endmodule

FILE: design/escape_char_percent_encoder_core.sv
// an accepted code unit is registered in the queue, then in cur_q, then in byte_q before output
// throughput: one byte per cycle while items wait and the consumer pops, set by the byte
//   sequencer in the back end; a passed unit gives 1 byte, a narrow escape 3 and a wide escape 6
// the classify queue of QueueDepth entries lets input run ahead of the output
// reset: asynchronous active low, clears queue pointers and valid flags
`timescale 1ns / 1ps

module escape_char_percent_encoder_core
  import epenc_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] code_unit_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o
);

  item_t f_item, q_item;
  logic q_push, q_pop, q_empty, q_full;

  epenc_front u_front (
    .push_i      (push),
    .code_unit_i (code_unit_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (f_item)
  );

  epenc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (f_item),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  epenc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_item_i   (q_item),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_byte_o (out_byte_o),
    .run_last_o (run_last_o)
  );

  assign full = q_full;

`ifndef SYNTHESIS
  // a percent sign always opens an escape, never ends one
  a_pct_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_byte_o == CH_PCT |-> !run_last_o)
    else $error("percent byte flagged as last");

  // the back end never drains an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // the rest of a run follows without a gap
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && !run_last_o |=> !empty)
    else $error("gap inside a run");
`endif

endmodule
